>>> sv/wmf_pkg.sv
package wmf_pkg;

  // fixed field widths of the channel beats
  localparam int unsigned CHANNEL_W    = 2;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned MODE_VALUE_W = 16;
  localparam int unsigned MODE_COUNT_W = 4;

  // largest count the result field can carry
  localparam logic [MODE_COUNT_W-1:0] MODE_COUNT_MAX = 4'd15;

  // default configuration of the core
  localparam int unsigned DEF_WINDOW      = 8;
  localparam int unsigned DEF_CHANNELS    = 4;
  localparam int unsigned DEF_SAMPLE_BITS = 16;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } wmf_state_e;

endpackage

>>> sv/wmf_if.sv
// input channel: one tagged sample per beat
interface wmf_in_if;
  logic                               valid;
  logic                               ready;
  logic [wmf_pkg::CHANNEL_W-1:0]      channel;
  logic [wmf_pkg::SAMPLE_W-1:0]       sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// output channel: one mode result per beat
interface wmf_out_if;
  logic                               valid;
  logic                               ready;
  logic [wmf_pkg::CHANNEL_W-1:0]      out_channel;
  logic [wmf_pkg::MODE_VALUE_W-1:0]   mode_value;
  logic [wmf_pkg::MODE_COUNT_W-1:0]   mode_count;

  modport source (output valid, output out_channel, output mode_value, output mode_count,
                  input ready);
  modport sink   (input valid, input out_channel, input mode_value, input mode_count,
                  output ready);
endinterface

>>> sv/wmf_match_count.sv
module wmf_match_count #(
  parameter int unsigned WINDOW      = wmf_pkg::DEF_WINDOW,
  parameter int unsigned SAMPLE_BITS = wmf_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned SLOT_W      = $clog2(WINDOW),
  parameter int unsigned CNT_W       = $clog2(WINDOW + 1)
) (
  input  logic [WINDOW-1:0][SAMPLE_BITS-1:0] win_i,
  input  logic [SLOT_W-1:0]                  idx_i,
  output logic [CNT_W-1:0]                   cnt_o
);

  logic [SAMPLE_BITS-1:0] probe;
  logic [WINDOW-1:0]      hit;

  // compare the selected slot against every slot of the window in parallel
  always_comb begin
    probe = win_i[idx_i];
    for (int k = 0; k < WINDOW; k++) begin
      hit[k] = (win_i[k] == probe);
    end
  end

  // number of equal slots
  assign cnt_o = CNT_W'($countones(hit));

endmodule

>>> sv/windowed_mode_filter_core.sv
// channel  direction  beat contents                              handshake
// in_i     sink       channel, sample                            valid/ready
// out_o    source     out_channel, mode_value, mode_count        valid/ready
//
// an accepted sample has its row read from the channel store, then merged and written
// back; then the shared match counter scores the window slot by slot. no new sample is
// taken until the scan has delivered its result to the output register.
// reset clears the per-channel row valid bits and write pointers; a row never
// written reads as zero, so no clearing pass is run.
// a result not yet taken sits in the output register; the scan holds on its last
// slot until that register frees up.
module windowed_mode_filter_core #(
  parameter int unsigned WINDOW      = wmf_pkg::DEF_WINDOW,
  parameter int unsigned CHANNELS    = wmf_pkg::DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS = wmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  wmf_in_if.sink           in_i,
  wmf_out_if.source        out_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [WINDOW-1:0][SAMPLE_BITS-1:0] row_t;

  wmf_pkg::wmf_state_e state_q, state_d;

  // channel store and its per-row state
  row_t                mem_q [CHANNELS];
  logic [CHANNELS-1:0] row_vld_q;
  logic [SLOT_W-1:0]   wr_slot_q [CHANNELS];

  // item registers
  logic [wmf_pkg::CHANNEL_W-1:0] ch_q, ch_d;
  logic [CH_W-1:0]               ch_idx, in_idx;
  logic [SAMPLE_BITS-1:0]        smp_q, smp_d;
  logic [SLOT_W-1:0]             slot_q;
  row_t                          rd_row_q;
  logic                          rd_vld_q;
  row_t                          win_q, merged_row;
  logic [SLOT_W-1:0]             idx_q, idx_d;
  logic [CNT_W-1:0]              best_cnt_q, cnt, sel_cnt;
  logic [SAMPLE_BITS-1:0]        best_val_q, sel_val;
  logic                          take, last, in_acc, out_load, out_free;
  logic [31:0]                   ch_ext, smp_ext, val_ext, cnt_ext;

  // output register
  logic                             out_vld_q, out_vld_d;
  logic [wmf_pkg::CHANNEL_W-1:0]    out_ch_q;
  logic [wmf_pkg::MODE_VALUE_W-1:0] out_val_q;
  logic [wmf_pkg::MODE_COUNT_W-1:0] out_cnt_q, out_cnt_sat;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;

  // channel folded into range, sample cut to the stored width
  always_comb begin
    ch_ext = 32'(in_i.channel);
    if (CHANNELS == 1) begin
      ch_ext = '0;
    end else if (ch_ext >= CHANNELS) begin
      ch_ext = ch_ext - CHANNELS;
    end
    ch_d    = ch_ext[wmf_pkg::CHANNEL_W-1:0];
    in_idx  = ch_ext[CH_W-1:0];
    smp_ext = 32'(in_i.sample);
    smp_d   = smp_ext[SAMPLE_BITS-1:0];
  end

  assign ch_idx = CH_W'(32'(ch_q));

  // stored row with unwritten rows as zero and the new sample dropped in
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      merged_row[k] = rd_vld_q ? rd_row_q[k] : '0;
      if (SLOT_W'(k) == slot_q) begin
        merged_row[k] = smp_q;
      end
    end
  end

  // shared match counter
  wmf_match_count #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SLOT_W      (SLOT_W),
    .CNT_W       (CNT_W)
  ) u_match_count (
    .win_i (win_q),
    .idx_i (idx_q),
    .cnt_o (cnt)
  );

  // running best, lowest slot kept on equal counts
  always_comb begin
    take    = (idx_q == '0) || (cnt > best_cnt_q);
    sel_cnt = take ? cnt : best_cnt_q;
    sel_val = take ? win_q[idx_q] : best_val_q;
    last    = (idx_q == SLOT_W'(WINDOW - 1));
    cnt_ext = 32'(sel_cnt);
    val_ext = 32'(sel_val);
    out_cnt_sat = (cnt_ext > 32'(wmf_pkg::MODE_COUNT_MAX)) ? wmf_pkg::MODE_COUNT_MAX
                                                           : cnt_ext[wmf_pkg::MODE_COUNT_W-1:0];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    out_load  = 1'b0;
    out_vld_d = out_vld_q && !out_o.ready;
    case (state_q)
      wmf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = wmf_pkg::ST_LOAD;
        end
      end
      wmf_pkg::ST_LOAD: begin
        idx_d   = '0;
        state_d = wmf_pkg::ST_SCAN;
      end
      wmf_pkg::ST_SCAN: begin
        if (!last) begin
          idx_d = idx_q + 1'b1;
        end else if (out_free) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = wmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wmf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wmf_pkg::ST_IDLE;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
      row_vld_q <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        wr_slot_q[c] <= '0;
      end
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
      if (state_q == wmf_pkg::ST_LOAD) begin
        row_vld_q[ch_idx] <= 1'b1;
        wr_slot_q[ch_idx] <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

  // channel store, registered read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_row_q <= mem_q[in_idx];
    end
    if (state_q == wmf_pkg::ST_LOAD) begin
      mem_q[ch_idx] <= merged_row;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q     <= ch_d;
      smp_q    <= smp_d;
      slot_q   <= wr_slot_q[in_idx];
      rd_vld_q <= row_vld_q[in_idx];
    end
    if (state_q == wmf_pkg::ST_LOAD) begin
      win_q <= merged_row;
    end
    if (state_q == wmf_pkg::ST_SCAN) begin
      best_cnt_q <= sel_cnt;
      best_val_q <= sel_val;
    end
    if (out_load) begin
      out_ch_q  <= ch_q;
      out_val_q <= val_ext[wmf_pkg::MODE_VALUE_W-1:0];
      out_cnt_q <= out_cnt_sat;
    end
  end

  assign in_i.ready        = (state_q == wmf_pkg::ST_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.mode_value  = out_val_q;
  assign out_o.mode_count  = out_cnt_q;

endmodule
